FILE: design/sjs_pkg.sv
package sjs_pkg;

	localparam int MAX_SAMPLES_DEF  = 512;
	localparam int CORDIC_STEPS_DEF = 16;
	localparam int ATAN_ENTRIES     = 24;

	localparam int RANGE_W = 16;
	localparam int INDEX_W = 9;
	localparam int POS_W   = 17;
	localparam int COUNT_W = 9;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 2;

	// CORDIC datapath: Q30 vectors and 1/2^32 turn angles, with headroom
	localparam int CW = 34;

	localparam logic [CFG_IDX_W-1:0] CFG_JUMP_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_STEP     = 2'd2;

	localparam logic [CFG_W-1:0] JUMP_THRESHOLD_RST = 16'd200;
	localparam logic [CFG_W-1:0] START_ANGLE_RST    = 16'd0;
	localparam logic [CFG_W-1:0] ANGLE_STEP_RST     = 16'd182;

	localparam logic [CW-1:0]      CORDIC_GAIN = 34'd652032874;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = 9'd511;
	localparam int                 POS_LIMIT   = 65535;

	function automatic logic [31:0] atan_entry(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

FILE: design/scan_jump_segmenter.sv
// Channel   Direction  Handshake            Payload
// in        request    in_valid/in_stall    range_mm, scan_end
// out       result     out_valid/out_stall  kind, nearest_index, nearest_range,
//                                           pos_x, pos_y, object_count, final_res
// cfg       write      cfg_we               cfg_index, cfg_data
//
// A request that closes no object and does not end the scan leaves the sequencer idle.
// A closing request steps through the sequencer in order: theta multiply,
// setup, one CORDIC rotation per cycle on the shared shift/add unit, quadrant fold,
// and two passes through the shared range multiplier. Scan end adds a summary result.
// in_stall is high while the sequencer is busy; a held result in the output
// register does not stall the next request until a new result has to be loaded.
// arst_n clears segmentation state and out_valid and resets configuration to its defaults.
module scan_jump_segmenter #(
	parameter int MAX_SAMPLES  = sjs_pkg::MAX_SAMPLES_DEF,
	parameter int CORDIC_STEPS = sjs_pkg::CORDIC_STEPS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sjs_pkg::RANGE_W-1:0]   range_mm,
	input  logic                          scan_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [sjs_pkg::INDEX_W-1:0]   nearest_index,
	output logic [sjs_pkg::RANGE_W-1:0]   nearest_range,
	output logic signed [sjs_pkg::POS_W-1:0] pos_x,
	output logic signed [sjs_pkg::POS_W-1:0] pos_y,
	output logic [sjs_pkg::COUNT_W-1:0]   object_count,
	output logic                          final_res,
	input  logic                          cfg_we,
	input  logic [sjs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sjs_pkg::CFG_W-1:0]     cfg_data
);
	import sjs_pkg::*;

	localparam int PW    = $clog2(MAX_SAMPLES);
	localparam int SW    = $clog2(CORDIC_STEPS);
	localparam int PRODW = RANGE_W + 1 + CW;

	localparam logic [PW-1:0] POS_LAST = PW'(MAX_SAMPLES - 1);
	localparam logic [SW-1:0] STEP_LAST = SW'(CORDIC_STEPS - 1);
	localparam logic signed [PRODW-1:0] ROUND_HALF = PRODW'(64'd1 << 29);
	localparam logic signed [PRODW-1:0] SAT_HI = PRODW'(POS_LIMIT);
	localparam logic signed [PRODW-1:0] SAT_LO = -PRODW'(POS_LIMIT);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_THETA,
		ST_INIT,
		ST_ROT,
		ST_QUAD,
		ST_MULX,
		ST_MULY,
		ST_EMIT_OBJ,
		ST_EMIT_SUM
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] thr_q, start_q, step_ang_q;

	logic [RANGE_W-1:0] prev_q, near_r_q;
	logic               inside_q;
	logic [PW-1:0]      near_p_q, sample_pos_q;
	logic [COUNT_W-1:0] count_q;

	logic [RANGE_W-1:0] job_range_q;
	logic [PW-1:0]      job_pos_q;
	logic               job_last_q;
	logic [COUNT_W-1:0] job_count_q;

	logic [15:0]          theta_q;
	logic [1:0]           quad_q;
	logic [SW-1:0]        step_q;
	logic signed [CW-1:0] x_q, y_q, z_q, cos_q, sin_q;
	logic signed [POS_W-1:0] px_q, py_q;

	logic                out_valid_q, kind_q, final_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [RANGE_W-1:0]  rng_q;
	logic signed [POS_W-1:0] ox_q, oy_q;
	logic [COUNT_W-1:0]  cnt_q;

	logic               accept, out_free, out_load;
	logic [RANGE_W:0]   diff_dn, diff_up;
	logic               drop, rise, paired, open_obj, close_obj, prev_lower;
	logic [RANGE_W-1:0] upd_r;
	logic [PW-1:0]      upd_p;
	logic [COUNT_W-1:0] count_next;
	logic [PW+15:0]     theta_prod;
	logic [15:0]        theta_plus, resid;
	logic [1:0]         quad_c;
	logic               rot_pos;
	logic signed [CW-1:0] xs, ys, atan_v;
	logic signed [RANGE_W:0] mul_a;
	logic signed [CW-1:0]    mul_b;
	logic signed [PRODW-1:0] prod, rounded;
	logic signed [POS_W-1:0] coord;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && (state_q inside {ST_EMIT_OBJ, ST_EMIT_SUM});

	always_comb begin
		diff_dn    = {1'b0, prev_q} - {1'b0, range_mm};
		diff_up    = {1'b0, range_mm} - {1'b0, prev_q};
		drop       = !diff_dn[RANGE_W] && (diff_dn[RANGE_W-1:0] > thr_q);
		rise       = !diff_up[RANGE_W] && (diff_up[RANGE_W-1:0] > thr_q);
		paired     = (sample_pos_q != '0);
		open_obj   = paired && !inside_q && drop;
		close_obj  = paired && inside_q && rise;
		prev_lower = (prev_q < near_r_q);
		upd_r      = prev_lower ? prev_q : near_r_q;
		upd_p      = prev_lower ? (sample_pos_q - PW'(1)) : near_p_q;
		count_next = (close_obj && (count_q < COUNT_MAX)) ? (count_q + COUNT_W'(1)) : count_q;

		theta_prod = job_pos_q * step_ang_q;
		theta_plus = theta_q + 16'h2000;
		quad_c     = theta_plus[15:14];
		resid      = theta_q - {quad_c, 14'h0};

		rot_pos = !z_q[CW-1];
		xs      = x_q >>> step_q;
		ys      = y_q >>> step_q;
		atan_v  = $signed({2'b00, atan_entry(5'(step_q))});

		mul_a   = $signed({1'b0, job_range_q});
		mul_b   = (state_q == ST_MULX) ? cos_q : sin_q;
		prod    = mul_a * mul_b;
		rounded = (prod + ROUND_HALF) >>> 30;
		if (rounded > SAT_HI) begin
			coord = POS_W'(SAT_HI);
		end else if (rounded < SAT_LO) begin
			coord = POS_W'(SAT_LO);
		end else begin
			coord = POS_W'(rounded);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			thr_q        <= JUMP_THRESHOLD_RST;
			start_q      <= START_ANGLE_RST;
			step_ang_q   <= ANGLE_STEP_RST;
			prev_q       <= '0;
			inside_q     <= 1'b0;
			near_r_q     <= '0;
			near_p_q     <= '0;
			sample_pos_q <= '0;
			count_q      <= '0;
			job_range_q  <= '0;
			job_pos_q    <= '0;
			job_last_q   <= 1'b0;
			job_count_q  <= '0;
			theta_q      <= '0;
			quad_q       <= '0;
			step_q       <= '0;
			x_q          <= '0;
			y_q          <= '0;
			z_q          <= '0;
			cos_q        <= '0;
			sin_q        <= '0;
			px_q         <= '0;
			py_q         <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= 1'b0;
			final_q      <= 1'b0;
			idx_q        <= '0;
			rng_q        <= '0;
			ox_q         <= '0;
			oy_q         <= '0;
			cnt_q        <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_JUMP_THRESHOLD: thr_q      <= cfg_data;
					CFG_START_ANGLE:    start_q    <= cfg_data;
					CFG_ANGLE_STEP:     step_ang_q <= cfg_data;
					default: ;
				endcase
			end

			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						prev_q      <= range_mm;
						job_last_q  <= scan_end;
						job_count_q <= count_next;
						job_range_q <= upd_r;
						job_pos_q   <= upd_p;
						if (scan_end) begin
							sample_pos_q <= '0;
							inside_q     <= 1'b0;
							near_r_q     <= '0;
							near_p_q     <= '0;
							count_q      <= '0;
						end else begin
							if (sample_pos_q < POS_LAST) begin
								sample_pos_q <= sample_pos_q + PW'(1);
							end
							count_q <= count_next;
							if (open_obj) begin
								inside_q <= 1'b1;
								near_r_q <= range_mm;
								near_p_q <= sample_pos_q;
							end else if (paired && inside_q) begin
								near_r_q <= upd_r;
								near_p_q <= upd_p;
								if (close_obj) begin
									inside_q <= 1'b0;
								end
							end
						end
						if (close_obj) begin
							state_q <= ST_THETA;
						end else if (scan_end) begin
							state_q <= ST_EMIT_SUM;
						end
					end
				end
				ST_THETA: begin
					theta_q <= start_q + theta_prod[15:0];
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					quad_q  <= quad_c;
					x_q     <= $signed(CORDIC_GAIN);
					y_q     <= '0;
					z_q     <= CW'($signed({resid, 16'h0}));
					step_q  <= '0;
					state_q <= ST_ROT;
				end
				ST_ROT: begin
					if (rot_pos) begin
						x_q <= x_q - ys;
						y_q <= y_q + xs;
						z_q <= z_q - atan_v;
					end else begin
						x_q <= x_q + ys;
						y_q <= y_q - xs;
						z_q <= z_q + atan_v;
					end
					step_q <= step_q + SW'(1);
					if (step_q == STEP_LAST) begin
						state_q <= ST_QUAD;
					end
				end
				ST_QUAD: begin
					case (quad_q)
						2'd1: begin
							cos_q <= -y_q;
							sin_q <= x_q;
						end
						2'd2: begin
							cos_q <= -x_q;
							sin_q <= -y_q;
						end
						2'd3: begin
							cos_q <= y_q;
							sin_q <= -x_q;
						end
						default: begin
							cos_q <= x_q;
							sin_q <= y_q;
						end
					endcase
					state_q <= ST_MULX;
				end
				ST_MULX: begin
					px_q    <= coord;
					state_q <= ST_MULY;
				end
				ST_MULY: begin
					py_q    <= coord;
					state_q <= ST_EMIT_OBJ;
				end
				ST_EMIT_OBJ: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= 1'b0;
						idx_q       <= INDEX_W'(job_pos_q);
						rng_q       <= job_range_q;
						ox_q        <= px_q;
						oy_q        <= py_q;
						cnt_q       <= '0;
						final_q     <= !job_last_q;
						state_q     <= job_last_q ? ST_EMIT_SUM : ST_IDLE;
					end
				end
				ST_EMIT_SUM: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						kind_q      <= 1'b1;
						idx_q       <= '0;
						rng_q       <= '0;
						ox_q        <= '0;
						oy_q        <= '0;
						cnt_q       <= job_count_q;
						final_q     <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign nearest_index = idx_q;
	assign nearest_range = rng_q;
	assign pos_x         = ox_q;
	assign pos_y         = oy_q;
	assign object_count  = cnt_q;
	assign final_res     = final_q;

	a_scan_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && scan_end |=> (sample_pos_q == '0) && !inside_q && (count_q == '0))
		else $error("scan end did not clear segmentation state");

	a_inside_has_pos: assert property (@(posedge clk) disable iff (!arst_n)
		inside_q |-> (sample_pos_q != '0))
		else $error("open object at sample position zero");

	a_summary_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_SUM) && out_free |=> out_valid && kind && final_res)
		else $error("summary result not loaded");

	a_object_not_last_of_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_OBJ) && out_free && job_last_q |=> (state_q == ST_EMIT_SUM))
		else $error("summary skipped after closing object at scan end");

endmodule
